/* hw/rtl/plint_pkg.sv */
// Shared types, constants and codes for the piecewise linear interpolator.
package plint_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int SLOT_W         = 4;
  localparam int COUNT_W        = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int QUEUE_DEPTH    = 2;
  // Quotient bits kept by the divider; anything at or above 2**QUO_W saturates.
  localparam int QUO_W          = 42;
  // Two quotient bits per divider cycle.
  localparam int DIV_STEPS      = QUO_W / 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } plint_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 1'b0,
    REG_EXTRAPOLATE = 1'b1
  } plint_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] point_count;
    logic               extrapolate;
  } plint_cfg_t;

  // Queue entry: a load carries the point in a/b, an evaluate carries the query in a.
  typedef struct packed {
    plint_op_t         op;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } plint_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PRIME,
    BK_SCAN,
    BK_DIFF,
    BK_MUL,
    BK_DIVINIT,
    BK_DIV,
    BK_FIN
  } plint_state_t;

endpackage

/* hw/rtl/piecewise_linear_interpolator.sv */
// Piecewise linear interpolator: top level with configuration registers.
// Load beat: written to the breakpoint RAMs by the idle back end; a new beat is taken
// while the queue has room. Evaluate beat: prime, a segment scan (one segment per cycle,
// up to MAX_POINTS-1 segments), difference, multiply, radix-4 divide and finish. Out of
// range without extrapolation the scan goes to finish; quotient overflow skips the divider.
// Reset (rst_n low, synchronous): queue empty, back end idle, point_count 2, extrapolate 0.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = plint_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration write port
  input  logic                                   cfg_we,
  input  logic        [plint_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [plint_pkg::COUNT_W-1:0]   cfg_wdata,
  // Input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_cmd,
  input  logic        [plint_pkg::SLOT_W-1:0]    in_point_index,
  input  logic signed [plint_pkg::DATA_W-1:0]    in_point_x,
  input  logic signed [plint_pkg::DATA_W-1:0]    in_point_y,
  input  logic signed [plint_pkg::DATA_W-1:0]    in_query_x,
  // Result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [plint_pkg::DATA_W-1:0]    out_value_y,
  output logic                                   out_valid_res,
  output logic                                   out_saturated
);

  plint_pkg::plint_cfg_t cfg_r, cfg_nxt;

  logic                   push_valid;
  logic                   push_ready;
  plint_pkg::plint_item_t push_item;
  logic                   pop_valid;
  logic                   pop_ready;
  plint_pkg::plint_item_t pop_item;

  // Configuration registers. Writes must arrive only while the block is idle; the block does
  // not enforce it. The back end reads them combinationally throughout an evaluation.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        plint_pkg::REG_POINT_COUNT: cfg_nxt.point_count = cfg_wdata;
        plint_pkg::REG_EXTRAPOLATE: cfg_nxt.extrapolate = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.point_count <= plint_pkg::COUNT_W'(2);
      cfg_r.extrapolate <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: classify each beat, drop loads that address a slot the table lacks,
  // and move evaluate queries into the common payload slot.
  plint_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_point_index (in_point_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_query_x     (in_query_x),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // Queue: loads and evaluates stay in order, so a load never overtakes an
  // evaluate that was accepted before it.
  plint_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back end: writes breakpoints, scans segments, runs multiply and divide,
  // and holds the finished result in an output register until it is taken.
  plint_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_y   (out_value_y),
    .out_valid_res (out_valid_res),
    .out_saturated (out_saturated)
  );

endmodule

/* hw/rtl/plint_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module plint_ram #(
  parameter int WIDTH = plint_pkg::DATA_W,
  parameter int DEPTH = plint_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* hw/rtl/plint_front.sv */
// Front end: accepts input beats, classifies them and drops loads to absent slots.
module plint_front #(
  parameter int MAX_POINTS = plint_pkg::MAX_POINTS_DEF
) (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic        [plint_pkg::SLOT_W-1:0] in_point_index,
  input  logic signed [plint_pkg::DATA_W-1:0] in_point_x,
  input  logic signed [plint_pkg::DATA_W-1:0] in_point_y,
  input  logic signed [plint_pkg::DATA_W-1:0] in_query_x,
  output logic                                push_valid,
  input  logic                                push_ready,
  output plint_pkg::plint_item_t              push_item
);

  logic is_eval;
  logic slot_ok;

  assign is_eval  = (in_cmd == plint_pkg::OP_EVAL);
  assign slot_ok  = (int'(in_point_index) < MAX_POINTS);

  // Take a beat whenever the queue has room; a dropped load simply vanishes.
  assign in_ready   = push_ready;
  assign push_valid = in_valid && (is_eval || slot_ok);

  always_comb begin
    push_item.op   = is_eval ? plint_pkg::OP_EVAL : plint_pkg::OP_LOAD;
    push_item.slot = in_point_index;
    push_item.a    = is_eval ? in_query_x : in_point_x;
    push_item.b    = in_point_y;
  end

endmodule

/* hw/rtl/plint_queue.sv */
// Short FIFO of classified items between the front end and the back end.
module plint_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  plint_pkg::plint_item_t push_item,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output plint_pkg::plint_item_t pop_item
);

  localparam int DEPTH = plint_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  plint_pkg::plint_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/plint_back.sv */
// Back end: breakpoint tables, segment scan, multiply, divide and result register.
module plint_back #(
  parameter int MAX_POINTS = plint_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plint_pkg::plint_cfg_t               cfg,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  plint_pkg::plint_item_t              pop_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [plint_pkg::DATA_W-1:0] out_value_y,
  output logic                                out_valid_res,
  output logic                                out_saturated
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = AW + 1;
  localparam int DW  = plint_pkg::DATA_W;
  localparam int QW  = plint_pkg::QUO_W;
  localparam int PW  = 2 * DW;
  localparam int RW  = QW + 2;
  localparam int SCW = $clog2(plint_pkg::DIV_STEPS);

  plint_pkg::plint_state_t state_r, state_nxt;

  logic [AW-1:0] seg_r, seg_nxt;
  logic [DW-1:0] qx_r, qx_nxt;
  logic [DW-1:0] xa_r, xa_nxt;
  logic [DW-1:0] ya_r, ya_nxt;
  logic [DW-1:0] xb_r, xb_nxt;
  logic [DW-1:0] yb_r, yb_nxt;
  logic          inval_r, inval_nxt;
  logic [DW-1:0] mdx_r, mdx_nxt;
  logic [DW-1:0] mdy_r, mdy_nxt;
  logic [DW-1:0] mden_r, mden_nxt;
  logic          neg_r, neg_nxt;
  logic          dz_r, dz_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] dq_r, dq_nxt;
  logic [SCW-1:0] step_r, step_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_value_r;
  logic          out_vres_r;
  logic          out_sat_r;
  logic          out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] rdx;
  logic [DW-1:0] rdy;

  logic [NW-1:0] n_use;
  logic [AW-1:0] last_seg;

  logic          below;
  logic          le_next;
  logic          is_last;

  logic signed [DW:0] dx, dy, den;

  logic [DW:0]   t0, t1;
  logic [DW-1:0] r0, r1;
  logic          b0, b1;

  logic signed [RW-1:0] ya_ext;
  logic signed [RW-1:0] q_ext;
  logic signed [RW-1:0] ysum;
  logic [RW-DW:0]       ysum_hi;
  logic [DW-1:0]        res_value;
  logic                 res_vres;
  logic                 res_sat;

  plint_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pop_item.a),
    .raddr (ram_raddr),
    .rdata (rdx)
  );

  plint_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pop_item.b),
    .raddr (ram_raddr),
    .rdata (rdy)
  );

  // Clamp the count into 2..MAX_POINTS; the last segment starts at count-2.
  always_comb begin
    if (cfg.point_count < plint_pkg::COUNT_W'(2)) begin
      n_use = NW'(2);
    end else if (int'(cfg.point_count) > MAX_POINTS) begin
      n_use = NW'(MAX_POINTS);
    end else begin
      n_use = NW'(cfg.point_count);
    end
    last_seg = AW'(n_use - NW'(2));
  end

  // Scan compares: xa_r holds x[seg], the RAM read data holds x[seg+1].
  assign below   = $signed(qx_r) < $signed(xa_r);
  assign le_next = $signed(qx_r) <= $signed(rdx);
  assign is_last = (seg_r == last_seg);

  // Segment differences, one bit wider than the coordinates.
  assign dx  = $signed({qx_r[DW-1], qx_r}) - $signed({xa_r[DW-1], xa_r});
  assign dy  = $signed({yb_r[DW-1], yb_r}) - $signed({ya_r[DW-1], ya_r});
  assign den = $signed({xb_r[DW-1], xb_r}) - $signed({xa_r[DW-1], xa_r});

  // Two restoring divide steps per cycle.
  always_comb begin
    t0 = {rem_r, dq_r[QW-1]};
    if (t0 >= {1'b0, mden_r}) begin
      r0 = DW'(t0 - {1'b0, mden_r});
      b0 = 1'b1;
    end else begin
      r0 = t0[DW-1:0];
      b0 = 1'b0;
    end
    t1 = {r0, dq_r[QW-2]};
    if (t1 >= {1'b0, mden_r}) begin
      r1 = DW'(t1 - {1'b0, mden_r});
      b1 = 1'b1;
    end else begin
      r1 = t1[DW-1:0];
      b1 = 1'b0;
    end
  end

  // Final add and clamp to the signed 32-bit range; an invalid result gives zero, a zero-width segment y[seg].
  always_comb begin
    ya_ext  = $signed({{(RW-DW){ya_r[DW-1]}}, ya_r});
    q_ext   = $signed({{(RW-QW){1'b0}}, dq_r});
    ysum    = neg_r ? (ya_ext - q_ext) : (ya_ext + q_ext);
    ysum_hi = ysum[RW-1:DW-1];
    if (inval_r) begin
      res_value = '0;
      res_vres  = 1'b0;
      res_sat   = 1'b0;
    end else if (dz_r) begin
      res_value = ya_r;
      res_vres  = 1'b1;
      res_sat   = 1'b0;
    end else if ((&ysum_hi) || !(|ysum_hi)) begin
      res_value = ysum[DW-1:0];
      res_vres  = 1'b1;
      res_sat   = 1'b0;
    end else begin
      res_value = ysum[RW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      res_vres  = 1'b1;
      res_sat   = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    qx_nxt    = qx_r;
    xa_nxt    = xa_r;
    ya_nxt    = ya_r;
    xb_nxt    = xb_r;
    yb_nxt    = yb_r;
    inval_nxt = inval_r;
    mdx_nxt   = mdx_r;
    mdy_nxt   = mdy_r;
    mden_nxt  = mden_r;
    neg_nxt   = neg_r;
    dz_nxt    = dz_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    step_nxt  = step_r;
    pop_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(pop_item.slot);
    ram_raddr = '0;
    out_load  = 1'b0;

    case (state_r)
      plint_pkg::BK_IDLE: begin
        if (pop_valid) begin
          pop_ready = 1'b1;
          if (pop_item.op == plint_pkg::OP_LOAD) begin
            ram_we = 1'b1;
          end else begin
            qx_nxt    = pop_item.a;
            ram_raddr = '0;
            state_nxt = plint_pkg::BK_PRIME;
          end
        end
      end
      plint_pkg::BK_PRIME: begin
        xa_nxt    = rdx;
        ya_nxt    = rdy;
        seg_nxt   = '0;
        ram_raddr = AW'(1);
        state_nxt = plint_pkg::BK_SCAN;
      end
      plint_pkg::BK_SCAN: begin
        // Prefetch the point after next; it is ignored if the scan stops here.
        ram_raddr = seg_r + AW'(2);
        if (below || le_next || is_last) begin
          xb_nxt    = rdx;
          yb_nxt    = rdy;
          inval_nxt = (below || !le_next) && !cfg.extrapolate;
          state_nxt = ((below || !le_next) && !cfg.extrapolate) ?
                      plint_pkg::BK_FIN : plint_pkg::BK_DIFF;
        end else begin
          xa_nxt  = rdx;
          ya_nxt  = rdy;
          seg_nxt = seg_r + AW'(1);
        end
      end
      plint_pkg::BK_DIFF: begin
        mdx_nxt   = dx[DW] ? DW'(-dx) : dx[DW-1:0];
        mdy_nxt   = dy[DW] ? DW'(-dy) : dy[DW-1:0];
        mden_nxt  = den[DW] ? DW'(-den) : den[DW-1:0];
        neg_nxt   = dx[DW] ^ dy[DW] ^ den[DW];
        dz_nxt    = (den == '0);
        state_nxt = plint_pkg::BK_MUL;
      end
      plint_pkg::BK_MUL: begin
        prod_nxt  = mdx_r * mdy_r;
        state_nxt = plint_pkg::BK_DIVINIT;
      end
      plint_pkg::BK_DIVINIT: begin
        // A high part at or above the divisor means the quotient overflows QW bits.
        if (DW'(prod_r[PW-1:QW]) >= mden_r) begin
          dq_nxt    = '1;
          state_nxt = plint_pkg::BK_FIN;
        end else begin
          rem_nxt   = DW'(prod_r[PW-1:QW]);
          dq_nxt    = prod_r[QW-1:0];
          step_nxt  = '0;
          state_nxt = plint_pkg::BK_DIV;
        end
      end
      plint_pkg::BK_DIV: begin
        rem_nxt  = r1;
        dq_nxt   = {dq_r[QW-3:0], b0, b1};
        step_nxt = step_r + SCW'(1);
        if (step_r == SCW'(plint_pkg::DIV_STEPS - 1)) begin
          state_nxt = plint_pkg::BK_FIN;
        end
      end
      plint_pkg::BK_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = plint_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = plint_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plint_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r   <= seg_nxt;
    qx_r    <= qx_nxt;
    xa_r    <= xa_nxt;
    ya_r    <= ya_nxt;
    xb_r    <= xb_nxt;
    yb_r    <= yb_nxt;
    inval_r <= inval_nxt;
    mdx_r   <= mdx_nxt;
    mdy_r   <= mdy_nxt;
    mden_r  <= mden_nxt;
    neg_r   <= neg_nxt;
    dz_r    <= dz_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    dq_r    <= dq_nxt;
    step_r  <= step_nxt;
    if (out_load) begin
      out_value_r <= res_value;
      out_vres_r  <= res_vres;
      out_sat_r   <= res_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_y   = $signed(out_value_r);
  assign out_valid_res = out_vres_r;
  assign out_saturated = out_sat_r;

endmodule

/* hw/rtl/plint_checker.sv */
// Port-level assertions for the interpolator and the bind that attaches them.
module plint_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   in_cmd,
  input logic        [plint_pkg::SLOT_W-1:0]    in_point_index,
  input logic signed [plint_pkg::DATA_W-1:0]    in_point_x,
  input logic signed [plint_pkg::DATA_W-1:0]    in_point_y,
  input logic signed [plint_pkg::DATA_W-1:0]    in_query_x,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [plint_pkg::DATA_W-1:0]    out_value_y,
  input logic                                   out_valid_res,
  input logic                                   out_saturated
);

  // Hold a stalled input beat.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_cmd) &&
      $stable(in_point_index) && $stable(in_point_x) && $stable(in_point_y) &&
      $stable(in_query_x))
    else $error("input beat changed while stalled");

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_y) &&
      $stable(out_valid_res) && $stable(out_saturated))
    else $error("result beat changed while stalled");

  // An invalid result carries zero and no saturation flag.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_value_y == '0 && !out_saturated)
    else $error("invalid result not cleared");

  // A saturated result sits at one end of the 32-bit range.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_value_y == 32'sh7FFF_FFFF || out_value_y == -32'sh8000_0000))
    else $error("saturated result off the rails");

  // Drop any pending result on reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind piecewise_linear_interpolator plint_checker u_plint_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_cmd         (in_cmd),
  .in_point_index (in_point_index),
  .in_point_x     (in_point_x),
  .in_point_y     (in_point_y),
  .in_query_x     (in_query_x),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_value_y    (out_value_y),
  .out_valid_res  (out_valid_res),
  .out_saturated  (out_saturated)
);

/* sim/plint_result_check.sv */
// Result checker for the piecewise linear interpolator: mirrors table and registers, predicts, compares.
module plint_result_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic        [plint_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [plint_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_cmd,
  input  logic        [plint_pkg::SLOT_W-1:0]    in_point_index,
  input  logic signed [plint_pkg::DATA_W-1:0]    in_point_x,
  input  logic signed [plint_pkg::DATA_W-1:0]    in_point_y,
  input  logic signed [plint_pkg::DATA_W-1:0]    in_query_x,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [plint_pkg::DATA_W-1:0]    out_value_y,
  input  logic                                out_valid_res,
  input  logic                                out_saturated,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import plint_pkg::*;

  localparam int     MAX_SLOTS   = MAX_POINTS_DEF;
  localparam longint QUOT_LIMIT  = 64'sh0000_0100_0000_0000;
  localparam longint INT32_HI    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint INT32_LO    = 64'shFFFF_FFFF_8000_0000;
  localparam int     PRINT_LIMIT = 100;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_y;
    logic                     valid_res;
    logic                     saturated;
  } interp_result_t;

  logic signed [DATA_W-1:0] knot_x [MAX_SLOTS];
  logic signed [DATA_W-1:0] knot_y [MAX_SLOTS];
  logic [COUNT_W-1:0]       count_reg;
  logic                     extrap_reg;
  interp_result_t           expected_q [$];
  interp_result_t           want;
  int                       errors = 0;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_val);
    if (errors < PRINT_LIMIT)
      $display("%0t: %s: got %h, want %h", $time, what, got, exp_val);
    errors++;
  endtask

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Line through knots i and i+1, evaluated at qx; product exact, quotient truncated.
  function automatic interp_result_t eval_segment(input longint qx, input int i);
    longint         x1, y1, dx, dy, den, r;
    logic [63:0]    q;
    logic           neg;
    interp_result_t res;
    x1  = knot_x[i];
    y1  = knot_y[i];
    dx  = qx - x1;
    dy  = longint'(knot_y[i+1]) - y1;
    den = longint'(knot_x[i+1]) - x1;
    r   = y1;
    if (den != 0) begin
      q   = (magnitude(dx) * magnitude(dy)) / magnitude(den);
      neg = ((dx < 0) != (dy < 0)) != (den < 0);
      if (q > 64'(QUOT_LIMIT))
        r = neg ? -QUOT_LIMIT : QUOT_LIMIT;
      else
        r = neg ? y1 - longint'(q) : y1 + longint'(q);
    end
    res.saturated = 1'b0;
    if (r > INT32_HI) begin
      r = INT32_HI;
      res.saturated = 1'b1;
    end else if (r < INT32_LO) begin
      r = INT32_LO;
      res.saturated = 1'b1;
    end
    res.value_y   = r[DATA_W-1:0];
    res.valid_res = 1'b1;
    return res;
  endfunction

  function automatic interp_result_t interpolate(input logic signed [DATA_W-1:0] qx_in);
    longint qx;
    int     n;
    qx = qx_in;
    n  = count_reg;
    if (n < 2) n = 2;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    for (int i = 0; i + 1 < n; i++) begin
      if (qx < knot_x[i]) begin
        if (extrap_reg) return eval_segment(qx, i);
        return '0;
      end
      if (qx <= knot_x[i+1]) return eval_segment(qx, i);
      if (i + 2 == n) begin
        if (extrap_reg) return eval_segment(qx, i);
        return '0;
      end
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      count_reg  = COUNT_W'(2);
      extrap_reg = 1'b0;
      expected_q.delete();
    end else begin
      // Retire a result beat first: it always belongs to an earlier query.
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with no query waiting", out_value_y, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_value_y !== want.value_y)
            report_mismatch("value_y", out_value_y, want.value_y);
          if (out_valid_res !== want.valid_res)
            report_mismatch("valid_res", DATA_W'(out_valid_res), DATA_W'(want.valid_res));
          if (out_saturated !== want.saturated)
            report_mismatch("saturated", DATA_W'(out_saturated), DATA_W'(want.saturated));
        end
      end
      if (in_valid && in_ready) begin
        if (in_cmd == OP_LOAD) begin
          if (int'(in_point_index) < MAX_SLOTS) begin
            knot_x[in_point_index] = in_point_x;
            knot_y[in_point_index] = in_point_y;
          end
        end else begin
          expected_q.push_back(interpolate(in_query_x));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT: count_reg  = cfg_wdata;
          REG_EXTRAPOLATE: extrap_reg = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending    <= expected_q.size();
    fail_count <= errors;
  end

endmodule

/* sim/testbench.sv */
// Top of the interpolator testbench: clock, reset, stimulus, receiver pacing and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import plint_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int ITEM_TARGET    = 1450;
  // Margin after the last answer so that loads queued behind an evaluate also finish.
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLDOFF_CYCLES = 500;
  // Watchdog budget: several times the slowest legal run of ITEM_TARGET beats with gaps,
  // result stalls and hold-offs.
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SLOTS          = MAX_POINTS_DEF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

  logic                     clk;
  logic                     rst_n          = 1'b0;
  logic                     cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index      = REG_POINT_COUNT;
  logic [COUNT_W-1:0]       cfg_wdata      = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic                     in_cmd         = OP_LOAD;
  logic [SLOT_W-1:0]        in_point_index = '0;
  logic signed [DATA_W-1:0] in_point_x     = '0;
  logic signed [DATA_W-1:0] in_point_y     = '0;
  logic signed [DATA_W-1:0] in_query_x     = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic signed [DATA_W-1:0] out_value_y;
  logic                     out_valid_res;
  logic                     out_saturated;
  int                       fail_count;
  int                       pending;

  int     cycle_count    = 0;
  int     items_sent     = 0;
  int     burst_left     = 0;
  bit     flood          = 1'b0;   // sender offers back to back, no gaps
  int     holdoff_wanted = 0;      // bumped by the stimulus
  int     holdoff_served = 0;      // bumped by the receiver
  int     active_count   = 2;      // breakpoints in use, after clamping
  longint stim_x [SLOTS];          // x last loaded per slot, used to aim queries

  piecewise_linear_interpolator dut (.*);

  plint_result_check result_check (.*);

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: stretches of random length, each with its own ready pattern.
  // A requested hold-off drops ready for a long run so the input side backs up.
  initial begin : receiver
    int hold_left;
    int stretch_left;
    int mode;
    hold_left    = 0;
    stretch_left = 0;
    mode         = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holdoff_served != holdoff_wanted) begin
        holdoff_served++;
        hold_left = HOLDOFF_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode         = $urandom_range(0, 3);
          stretch_left = $urandom_range(8, 60);
        end
        stretch_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 0);
          2:       out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Pick a query: mostly inside a segment, some on knots, beyond the ends and raw.
  function automatic logic signed [DATA_W-1:0] random_query();
    int     sel;
    int     k;
    longint lo, hi;
    sel = $urandom_range(0, 15);
    if (sel <= 8) begin
      k  = $urandom_range(0, active_count - 2);
      lo = stim_x[k];
      hi = stim_x[k+1];
      if (hi <= lo) return clamp_q16(lo);
      return clamp_q16(lo + longint'($urandom) % (hi - lo + 1));
    end
    if (sel <= 10) return clamp_q16(stim_x[$urandom_range(0, active_count - 1)]);
    if (sel == 11) return clamp_q16(stim_x[0] - longint'($urandom_range(1, 1 << 20)));
    if (sel == 12)
      return clamp_q16(stim_x[active_count-1] + longint'($urandom_range(1, 1 << 20)));
    if (sel == 13) return ($urandom_range(0, 1) == 0) ? Q_MIN : Q_MAX;
    return $urandom;
  endfunction

  // Write one register with a one-cycle enable pulse so back-to-back writes don't collide.
  task automatic write_reg(input plint_reg_t idx, input logic [COUNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pacing: bursts of random length, random gaps between them, none while flooding.
  task automatic pace();
    int gap;
    if (flood) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offer one beat and hold it until accepted. Valid stays up into the next beat
  // unless pacing drops it.
  task automatic send_beat(input plint_op_t op, input logic [SLOT_W-1:0] slot,
                           input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                           input logic [DATA_W-1:0] qx);
    in_valid       <= 1'b1;
    in_cmd         <= op;
    in_point_index <= slot;
    in_point_x     <= px;
    in_point_y     <= py;
    in_query_x     <= qx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    pace();
  endtask

  // Loads carry a random query field; evaluates carry random point fields.
  task automatic load_point(input logic [SLOT_W-1:0] slot, input logic signed [DATA_W-1:0] px,
                            input logic signed [DATA_W-1:0] py);
    stim_x[slot] = px;
    send_beat(OP_LOAD, slot, px, py, $urandom);
  endtask

  task automatic eval_query(input logic signed [DATA_W-1:0] qx);
    send_beat(OP_EVAL, SLOT_W'($urandom), $urandom, $urandom, qx);
  endtask

  // Wait until every query is answered, then let trailing loads finish.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reconfigure only with the block idle. Upper data bits of the mode write are junk.
  task automatic configure(input logic [COUNT_W-1:0] count, input logic extrap);
    logic [COUNT_W-1:0] mode_word;
    settle();
    mode_word    = COUNT_W'($urandom);
    mode_word[0] = extrap;
    write_reg(REG_POINT_COUNT, count);
    write_reg(REG_EXTRAPOLATE, mode_word);
    active_count = int'(count);
    if (active_count < 2) active_count = 2;
    if (active_count > SLOTS) active_count = SLOTS;
  endtask

  // Fixed table: increasing knots, then an equal-x pair, a step back, and the top of range.
  task automatic load_directed_table();
    longint x, y;
    for (int i = 0; i < SLOTS; i++) begin
      if (i <= 12) x = (longint'(i) - 8) * (longint'(1) << 24);
      else if (i == 13) x = longint'(1) << 26;
      else if (i == 14) x = (longint'(1) << 26) - (longint'(1) << 20);
      else x = Q_MAX;
      if (i == 1) y = Q_MAX;
      else if (i == 2) y = Q_MIN;
      else y = (longint'(i) * 3 - 20) * 65536;
      load_point(SLOT_W'(i), clamp_q16(x), clamp_q16(y));
    end
  endtask

  // Fill every slot with increasing x at a random scale; now and then two knots share x.
  task automatic load_random_table();
    int     step_max;
    int     y_mode;
    longint span;
    longint x;
    logic signed [DATA_W-1:0] y;
    case ($urandom_range(0, 3))
      0:       step_max = 16;
      1:       step_max = 4096;
      2:       step_max = 1 << 20;
      default: step_max = 1 << 27;
    endcase
    span   = longint'(Q_MAX) - longint'(Q_MIN) - 15 * longint'(step_max) + 1;
    x      = longint'(Q_MIN) + longint'($urandom) % span;
    y_mode = $urandom_range(0, 2);
    for (int i = 0; i < SLOTS; i++) begin
      if (i > 0 && $urandom_range(0, 11) != 0) x += longint'($urandom_range(1, step_max));
      case (y_mode)
        0:       y = $urandom;
        1:       y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        default: y = ($urandom_range(0, 1) == 0) ? Q_MIN : Q_MAX;
      endcase
      load_point(SLOT_W'(i), clamp_q16(x), y);
    end
  endtask

  initial begin : stimulus
    int                 phase;
    int                 n_items;
    logic [COUNT_W-1:0] count_val;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every slot written before any query, so no scan hits an empty slot.
    configure(COUNT_W'(16), 1'b1);
    load_directed_table();
    eval_query(Q_MIN);                                   // far below, extrapolates into clamp
    eval_query(Q_MAX);                                   // lands on the last knot
    eval_query(clamp_q16(stim_x[5]));                    // exactly on a knot
    eval_query(clamp_q16((stim_x[1] + stim_x[2]) / 2));  // steepest segment, mid point
    eval_query('0);
    configure(COUNT_W'(15), 1'b1);                       // end segment runs backward in x
    eval_query(Q_MAX);
    configure(COUNT_W'(14), 1'b1);                       // end segment has zero width
    eval_query(Q_MAX);
    configure(COUNT_W'(31), 1'b0);                       // count above the table size
    eval_query(Q_MIN);
    eval_query(clamp_q16(stim_x[0]));
    configure(COUNT_W'(0), 1'b0);                        // count below two
    eval_query(clamp_q16(longint'(1) << 26));
    configure(COUNT_W'(1), 1'b1);
    eval_query(Q_MAX);

    // Random phases: new setting, usually a fresh well-formed table, then mostly queries
    // with the odd stray load that may break the ordering.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       count_val = COUNT_W'($urandom_range(0, 1));
        1:       count_val = COUNT_W'($urandom_range(17, 31));
        2:       count_val = COUNT_W'(16);
        3:       count_val = COUNT_W'(2);
        default: count_val = COUNT_W'($urandom_range(3, 15));
      endcase
      configure(count_val, 1'($urandom));
      // Now and then hold the receiver off and flood the input so the block backs up.
      if (phase % 6 == 1) begin
        holdoff_wanted++;
        flood = 1'b1;
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) load_random_table();
      n_items = $urandom_range(30, 70);
      repeat (n_items) begin
        if ($urandom_range(0, 11) == 0)
          load_point(SLOT_W'($urandom), $urandom, $urandom);
        else
          eval_query(random_query());
      end
      flood = 1'b0;
      phase++;
    end

    settle();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
